// File: hw/rtl/cpr_pkg.sv
// Shared constants for the clock page replacement block.
`default_nettype none

package cpr_pkg;

    localparam int FRAMES_DEFAULT    = 16;
    localparam int PAGE_BITS_DEFAULT = 16;

    localparam int CFG_W       = 5;
    localparam int FRAME_OUT_W = 4;
    localparam int FAULT_W     = 32;

    localparam logic [CFG_W-1:0]   FRAMES_IN_USE_RESET = CFG_W'(16);
    localparam logic [FAULT_W-1:0] FAULT_MAX           = '1;

    // page queue between the front and back parts
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

`default_nettype wire

// File: hw/rtl/cpr_if.sv
// Handshake channels of the clock page replacement block.
`default_nettype none

interface page_if
    import cpr_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEFAULT
);
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page;

    modport source (output valid, output page, input ready);
    modport sink   (input valid, input page, output ready);
endinterface

interface result_if
    import cpr_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEFAULT
);
    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic [FRAME_OUT_W-1:0] frame;
    logic                   evicted_valid;
    logic [PAGE_BITS-1:0]   evicted_page;
    logic [FAULT_W-1:0]     fault_count;

    modport source (output valid, output hit, output frame, output evicted_valid,
                    output evicted_page, output fault_count, input ready);
    modport sink   (input valid, input hit, input frame, input evicted_valid,
                    input evicted_page, input fault_count, output ready);
endinterface

interface cfg_if
    import cpr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] frames_in_use;

    modport source (output valid, output frames_in_use, input ready);
    modport sink   (input valid, input frames_in_use, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/clock_page_replacement.sv
// Clock (second chance) page replacement unit, top level.
// One page reference per req word gives one rsp word. A hit or the fill of an empty
// frame passes queue pop, then tag match and result register in the back engine;
// an eviction adds a sweep in which the hand clears set reference bits on its way,
// one frame per cycle, until it takes a victim. A two-word queue in front takes new
// references while the engine works, and the result register holds a word until the
// sink takes it. frames_in_use is to be written on cfg only while idle; the block
// itself does not enforce it. 0 acts as 1, values above FRAMES act as FRAMES. Frame
// page tags are not cleared at reset, no clearing pass is needed.
`default_nettype none

module clock_page_replacement
    import cpr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEFAULT,
    parameter int PAGE_BITS = PAGE_BITS_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    page_if.sink      req,
    result_if.source  rsp,
    cfg_if.sink       cfg
);

    logic [CFG_W-1:0]     frames_in_use_reg;
    logic                 q_valid;
    logic [PAGE_BITS-1:0] q_page;
    logic                 q_pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= FRAMES_IN_USE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            frames_in_use_reg <= cfg.frames_in_use;
        end
    end

    cpr_front #(
        .PAGE_BITS (PAGE_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_page  (q_page),
        .q_pop   (q_pop)
    );

    cpr_back #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .frames_in_use (frames_in_use_reg),
        .q_valid       (q_valid),
        .q_page        (q_page),
        .q_pop         (q_pop),
        .rsp           (rsp)
    );

endmodule

`default_nettype wire

// File: hw/rtl/cpr_front.sv
// Front part: accepts page references into a short queue for the back part.
`default_nettype none

module cpr_front
    import cpr_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    page_if.sink                      req,
    output logic                      q_valid,
    output logic [PAGE_BITS-1:0]      q_page,
    input  wire logic                 q_pop
);

    logic [PAGE_BITS-1:0] slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [QCNT_W-1:0]    count_reg;
    logic [QCNT_W-1:0]    count_next;
    logic                 push;
    logic                 pop;

    assign req.ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign q_valid   = (count_reg != '0);
    assign pop       = q_pop && q_valid;
    assign q_page    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= req.page;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/cpr_back.sv
// Back part: tag match, fill, clock sweep and the registered result word.
`default_nettype none

module cpr_back
    import cpr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEFAULT,
    parameter int PAGE_BITS = PAGE_BITS_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [CFG_W-1:0]     frames_in_use,
    input  wire logic                 q_valid,
    input  wire logic [PAGE_BITS-1:0] q_page,
    output logic                      q_pop,
    result_if.source                  rsp
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW    = $clog2(FRAMES + 1);
    localparam int N_W   = (CW > CFG_W) ? CW : CFG_W;

    typedef enum logic [1:0] {S_IDLE, S_MATCH, S_SWEEP} state_t;

    state_t               state_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [IDX_W-1:0]     hand_reg;
    logic [FAULT_W-1:0]   faults_reg;
    logic [FRAMES-1:0]    valid_reg;
    logic [FRAMES-1:0]    ref_reg;
    logic [PAGE_BITS-1:0] page_mem [FRAMES];

    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic [FRAME_OUT_W-1:0] out_frame_reg;
    logic                   out_ev_valid_reg;
    logic [PAGE_BITS-1:0]   out_ev_page_reg;
    logic [FAULT_W-1:0]     out_faults_reg;

    logic [N_W-1:0]     cfg_ext;
    logic [N_W-1:0]     n_eff;
    logic [FRAMES-1:0]  in_range;
    logic [FRAMES-1:0]  match_vec;
    logic [FRAMES-1:0]  empty_vec;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   empty_idx;
    logic [IDX_W-1:0]   hand_start;
    logic [FAULT_W-1:0] fault_sat;
    logic               start;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;

    function automatic logic [IDX_W-1:0] lowest_set(input logic [FRAMES-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = IDX_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
                                                  input logic [N_W-1:0]   n);
        logic [IDX_W-1:0] r;
        if (N_W'(i) + N_W'(1) >= n)
        begin
            r = '0;
        end
        else
        begin
            r = i + IDX_W'(1);
        end
        return r;
    endfunction

    function automatic logic [FRAME_OUT_W-1:0] to_frame(input logic [IDX_W-1:0] i);
        logic [FRAME_OUT_W+IDX_W-1:0] w;
        w = {{FRAME_OUT_W{1'b0}}, i};
        return w[FRAME_OUT_W-1:0];
    endfunction

    // zero counts as one frame, anything above the built count as the built count
    assign cfg_ext = N_W'(frames_in_use);

    always_comb
    begin
        if (cfg_ext == '0)
        begin
            n_eff = N_W'(1);
        end
        else if (cfg_ext > N_W'(FRAMES))
        begin
            n_eff = N_W'(FRAMES);
        end
        else
        begin
            n_eff = cfg_ext;
        end
    end

    for (genvar g = 0; g < FRAMES; g++)
    begin : g_lane
        assign in_range[g]  = (N_W'(g) < n_eff);
        assign match_vec[g] = valid_reg[g] && in_range[g] && (page_mem[g] == page_reg);
        assign empty_vec[g] = !valid_reg[g] && in_range[g];
    end

    assign hit_idx    = lowest_set(match_vec);
    assign empty_idx  = lowest_set(empty_vec);
    assign hand_start = (N_W'(hand_reg) >= n_eff) ? '0 : hand_reg;
    assign fault_sat  = (faults_reg == FAULT_MAX) ? faults_reg : faults_reg + FAULT_W'(1);

    assign start = (state_reg == S_IDLE) && q_valid && (!out_valid_reg || rsp.ready);
    assign q_pop = start;

    assign mem_we = ((state_reg == S_MATCH) && !(|match_vec) && (|empty_vec))
                 || ((state_reg == S_SWEEP) && !ref_reg[hand_reg]);
    assign mem_waddr = (state_reg == S_MATCH) ? empty_idx : hand_reg;

    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = out_hit_reg;
    assign rsp.frame         = out_frame_reg;
    assign rsp.evicted_valid = out_ev_valid_reg;
    assign rsp.evicted_page  = out_ev_page_reg;
    assign rsp.fault_count   = out_faults_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            page_reg         <= '0;
            hand_reg         <= '0;
            faults_reg       <= '0;
            valid_reg        <= '0;
            ref_reg          <= '0;
            out_valid_reg    <= 1'b0;
            out_hit_reg      <= 1'b0;
            out_frame_reg    <= '0;
            out_ev_valid_reg <= 1'b0;
            out_ev_page_reg  <= '0;
            out_faults_reg   <= '0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        page_reg  <= q_page;
                        hand_reg  <= hand_start;
                        state_reg <= S_MATCH;
                    end
                end
                S_MATCH:
                begin
                    if (|match_vec)
                    begin
                        ref_reg[hit_idx] <= 1'b1;
                        out_valid_reg    <= 1'b1;
                        out_hit_reg      <= 1'b1;
                        out_frame_reg    <= to_frame(hit_idx);
                        out_ev_valid_reg <= 1'b0;
                        out_ev_page_reg  <= '0;
                        out_faults_reg   <= faults_reg;
                        state_reg        <= S_IDLE;
                    end
                    else
                    begin
                        faults_reg <= fault_sat;
                        if (|empty_vec)
                        begin
                            valid_reg[empty_idx] <= 1'b1;
                            ref_reg[empty_idx]   <= 1'b0;
                            hand_reg             <= next_idx(empty_idx, n_eff);
                            out_valid_reg        <= 1'b1;
                            out_hit_reg          <= 1'b0;
                            out_frame_reg        <= to_frame(empty_idx);
                            out_ev_valid_reg     <= 1'b0;
                            out_ev_page_reg      <= '0;
                            out_faults_reg       <= fault_sat;
                            state_reg            <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_SWEEP;
                        end
                    end
                end
                S_SWEEP:
                begin
                    // one frame per cycle: clear and skip, or take it as victim
                    hand_reg <= next_idx(hand_reg, n_eff);
                    if (ref_reg[hand_reg])
                    begin
                        ref_reg[hand_reg] <= 1'b0;
                    end
                    else
                    begin
                        out_valid_reg    <= 1'b1;
                        out_hit_reg      <= 1'b0;
                        out_frame_reg    <= to_frame(hand_reg);
                        out_ev_valid_reg <= 1'b1;
                        out_ev_page_reg  <= page_mem[hand_reg];
                        out_faults_reg   <= faults_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            page_mem[mem_waddr] <= page_reg;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/cpr_checker.sv
// Port-level assertions for the clock page replacement block, with its bind.
`default_nettype none

module cpr_checker
    import cpr_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEFAULT
)
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 rsp_valid,
    input wire logic                 rsp_ready,
    input wire logic                 rsp_hit,
    input wire logic                 rsp_evicted_valid,
    input wire logic [PAGE_BITS-1:0] rsp_evicted_page,
    input wire logic [FAULT_W-1:0]   rsp_fault_count
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp word dropped while stalled");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_hit |-> !rsp_evicted_valid)
        else $error("hit reports an eviction");

    a_no_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_evicted_valid |-> rsp_evicted_page == '0)
        else $error("evicted page nonzero without eviction");

    a_miss_counted: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_hit |-> rsp_fault_count != '0)
        else $error("fault not counted");

endmodule

bind clock_page_replacement cpr_checker #(
    .PAGE_BITS (PAGE_BITS)
) u_cpr_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_hit           (rsp.hit),
    .rsp_evicted_valid (rsp.evicted_valid),
    .rsp_evicted_page  (rsp.evicted_page),
    .rsp_fault_count   (rsp.fault_count)
);

`default_nettype wire
